### design/pure_pursuit_lookahead_target_assert.svh
// ----------------------------------------------------------------------------
// pure pursuit lookahead target assertion macros
// property macros for implication checks, removable with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef PURE_PURSUIT_LOOKAHEAD_TARGET_ASSERT_SVH
`define PURE_PURSUIT_LOOKAHEAD_TARGET_ASSERT_SVH

`ifndef ASSERT_OFF
`define PPLT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PPLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PPLT_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define PPLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### design/pplt_pkg.sv
// ----------------------------------------------------------------------------
// pplt_pkg
// shared types, codes and helpers of the pure pursuit lookahead target block
// ----------------------------------------------------------------------------
package pplt_pkg;

    localparam int MAX_POINTS_DEF     = 1024;
    localparam int HORIZON_POINTS_DEF = 100;
    localparam logic [30:0] LAD_RESET = 31'd327680;
    localparam int DSQ_W = 65;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } t_req;

    typedef struct packed {
        logic signed [31:0] target_local_x;
        logic signed [31:0] target_local_y;
        logic [9:0]         target_index;
        logic               path_present;
    } t_res;

    // magnitude of a 33 bit signed value known to stay below 2^32
    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic [32:0] m;
        m = v[32] ? 33'(-v) : 33'(v);
        return m[31:0];
    endfunction

endpackage

### design/pure_pursuit_lookahead_target.sv
// ----------------------------------------------------------------------------
// pure_pursuit_lookahead_target
// path store with nearest point search, lookahead scan and frame rotation
// ----------------------------------------------------------------------------
// Clear and append requests stay in the idle state; an append to a full path is
// dropped. A query walks the stored path once through the single read port of
// the path memory (one point per cycle) to find the nearest point, then walks
// at most HORIZON_POINTS points from there for the first one at or beyond the
// lookahead radius, then reads that point and rotates the offset into the
// vehicle frame. The heading unit (bit serial square root and two 62 step
// divisions) runs alongside the scan, and the rotation does not start before
// it is done. A query on an empty path skips the search and answers with a
// zeroed result. The result sits in an output register, so clear and append
// requests go on while it waits to be taken.
`include "pure_pursuit_lookahead_target_assert.svh"

module pure_pursuit_lookahead_target import pplt_pkg::*; #(
    parameter int MAX_POINTS     = MAX_POINTS_DEF,
    parameter int HORIZON_POINTS = HORIZON_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_req        i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_res        o_out_res,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_NEAR  = 6'b000010,
        ST_WIN   = 6'b000100,
        ST_FETCH = 6'b001000,
        ST_ROT   = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state             r_state;
    logic [30:0]        r_lad;
    logic [61:0]        r_lim;
    logic [CW-1:0]      r_cnt;
    logic [31:0]        r_px, r_py;
    logic [CW-1:0]      r_rd_addr, r_end;
    logic               r_issue;
    logic               r_rd_vld;
    logic [AW:0]        r_rd_tag;
    logic [DSQ_W-1:0]   r_best;
    logic [AW-1:0]      r_near, r_target;
    logic               r_found, r_fph, r_rot_go, r_empty;
    logic signed [32:0] r_dx, r_dy;
    logic               r_out_vld;
    t_res               r_out;

    logic               n_accept, n_append, n_we, n_re;
    logic [AW-1:0]      n_raddr;
    logic [63:0]        n_rdata;
    logic               n_last_issue;
    logic               d_vld;
    logic [DSQ_W-1:0]   d_dsq;
    logic [AW:0]        d_tag;
    logic [AW-1:0]      d_idx;
    logic               d_last;
    logic [AW-1:0]      n_near, n_target;
    logic [31:0]        n_end_w;
    logic [CW-1:0]      n_end;
    logic               hdg_done, rot_start, rot_done;
    logic signed [31:0] hdg_cos, hdg_sin, rot_x, rot_y;
    logic               n_out_load;
    logic [31:0]        n_idx_w;

    assign o_in_stall = (r_state != ST_IDLE);
    assign n_accept   = i_in_valid && !o_in_stall;
    assign n_append   = n_accept && i_in_req.mode == MODE_APPEND;
    assign n_we       = n_append && r_cnt < CW'(MAX_POINTS);

    assign n_last_issue = (r_rd_addr + CW'(1) == r_end);
    assign n_re    = r_issue || (r_state == ST_FETCH && !r_fph);
    assign n_raddr = r_issue ? r_rd_addr[AW-1:0] : r_target;

    assign d_idx  = d_tag[AW-1:0];
    assign d_last = d_tag[AW];
    assign n_near = (d_idx == '0 || d_dsq < r_best) ? d_idx : r_near;
    assign n_end_w = (32'(r_cnt) - 32'(n_near) > 32'(HORIZON_POINTS))
                   ? 32'(n_near) + 32'(HORIZON_POINTS) : 32'(r_cnt);
    assign n_end    = n_end_w[CW-1:0];
    assign n_target = (!r_found && !(d_dsq < {3'd0, r_lim})) ? d_idx : r_target;

    assign rot_start  = (r_state == ST_ROT) && !r_rot_go && hdg_done;
    assign n_out_load = (r_state == ST_DONE) && (!r_out_vld || !i_out_stall);
    assign n_idx_w    = 32'(r_target);

    pplt_path_mem #(.MAX_POINTS(MAX_POINTS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata ({i_in_req.pos_x, i_in_req.pos_y}),
        .i_re    (n_re),
        .i_raddr (n_raddr),
        .o_rdata (n_rdata)
    );

    pplt_dist #(.TAG_W(AW + 1)) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_rd_vld),
        .i_tx    (n_rdata[63:32]),
        .i_ty    (n_rdata[31:0]),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_tag   (r_rd_tag),
        .o_vld   (d_vld),
        .o_dsq   (d_dsq),
        .o_tag   (d_tag)
    );

    pplt_heading u_hdg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_accept && i_in_req.mode == MODE_QUERY && r_cnt != '0),
        .i_qw    (i_in_req.quat_w),
        .i_qx    (i_in_req.quat_x),
        .i_qy    (i_in_req.quat_y),
        .i_qz    (i_in_req.quat_z),
        .o_done  (hdg_done),
        .o_cos   (hdg_cos),
        .o_sin   (hdg_sin)
    );

    pplt_rotate u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rot_start),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .i_cos   (hdg_cos),
        .i_sin   (hdg_sin),
        .o_done  (rot_done),
        .o_x     (rot_x),
        .o_y     (rot_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lad <= LAD_RESET;
        end else if (i_cfg_we) begin
            r_lad <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim <= {31'd0, r_lad} * {31'd0, r_lad};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_issue   <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_rot_go  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_issue;
            if (r_issue) begin
                r_rd_addr <= r_rd_addr + CW'(1);
                if (n_last_issue) r_issue <= 1'b0;
            end
            if (n_out_load) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (n_accept) begin
                        case (i_in_req.mode)
                            MODE_CLEAR: r_cnt <= '0;
                            MODE_APPEND: if (n_we) r_cnt <= r_cnt + CW'(1);
                            MODE_QUERY: begin
                                if (r_cnt == '0) begin
                                    r_state <= ST_DONE;
                                end else begin
                                    r_state   <= ST_NEAR;
                                    r_rd_addr <= '0;
                                    r_end     <= r_cnt;
                                    r_issue   <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_NEAR: begin
                    if (d_vld && d_last) begin
                        r_state   <= ST_WIN;
                        r_rd_addr <= CW'(n_near);
                        r_end     <= n_end;
                        r_issue   <= 1'b1;
                    end
                end
                ST_WIN: begin
                    if (d_vld && d_last) r_state <= ST_FETCH;
                end
                ST_FETCH: begin
                    if (r_fph) begin
                        r_state  <= ST_ROT;
                        r_rot_go <= 1'b0;
                    end
                end
                ST_ROT: begin
                    if (rot_start) r_rot_go <= 1'b1;
                    if (r_rot_go && rot_done) r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (n_out_load) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rd_tag <= {n_last_issue, r_rd_addr[AW-1:0]};
        case (r_state)
            ST_IDLE: begin
                r_px    <= i_in_req.pos_x;
                r_py    <= i_in_req.pos_y;
                r_empty <= (r_cnt == '0);
                r_fph   <= 1'b0;
            end
            ST_NEAR: begin
                if (d_vld) begin
                    if (d_idx == '0 || d_dsq < r_best) r_best <= d_dsq;
                    r_near <= n_near;
                    if (d_last) begin
                        r_found  <= 1'b0;
                        r_target <= AW'(n_end - CW'(1));
                    end
                end
            end
            ST_WIN: begin
                if (d_vld) begin
                    r_target <= n_target;
                    if (!(d_dsq < {3'd0, r_lim})) r_found <= 1'b1;
                end
            end
            ST_FETCH: begin
                r_fph <= 1'b1;
                if (r_fph) begin
                    r_dx <= $signed({n_rdata[63], n_rdata[63:32]})
                          - $signed({r_px[31], r_px});
                    r_dy <= $signed({n_rdata[31], n_rdata[31:0]})
                          - $signed({r_py[31], r_py});
                end
            end
            default: ;
        endcase
        if (n_out_load) begin
            if (r_empty) begin
                r_out <= '0;
            end else begin
                r_out.target_local_x <= rot_x;
                r_out.target_local_y <= rot_y;
                r_out.target_index   <= n_idx_w[9:0];
                r_out.path_present   <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_res   = r_out;

    `PPLT_ASSERT_SAME(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(MAX_POINTS))
    `PPLT_ASSERT_SAME(a_rot_after_hdg, i_clk, i_rst_n, rot_start, hdg_done)
    `PPLT_ASSERT_SAME(a_target_in_win, i_clk, i_rst_n, r_state == ST_ROT, CW'(r_target) < r_end)
    `PPLT_ASSERT_NEXT(a_done_loads, i_clk, i_rst_n, n_out_load, o_out_valid && r_state == ST_IDLE)

endmodule

### design/pplt_path_mem.sv
// ----------------------------------------------------------------------------
// pplt_path_mem
// path point store, one write and one registered read port
// ----------------------------------------------------------------------------
module pplt_path_mem import pplt_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    localparam int AW = $clog2(MAX_POINTS)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata
);

    logic [63:0] r_mem [MAX_POINTS];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/pplt_dist.sv
// ----------------------------------------------------------------------------
// pplt_dist
// three stage squared distance pipeline with a passing tag
// ----------------------------------------------------------------------------
module pplt_dist import pplt_pkg::*; #(
    parameter int TAG_W = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic [31:0]        i_tx,
    input  logic [31:0]        i_ty,
    input  logic [31:0]        i_px,
    input  logic [31:0]        i_py,
    input  logic [TAG_W-1:0]   i_tag,
    output logic               o_vld,
    output logic [DSQ_W-1:0]   o_dsq,
    output logic [TAG_W-1:0]   o_tag
);

    logic               r_vld_a, r_vld_b, r_vld_c;
    logic [TAG_W-1:0]   r_tag_a, r_tag_b, r_tag_c;
    logic [31:0]        r_mx, r_my;
    logic [63:0]        r_sx, r_sy;
    logic [DSQ_W-1:0]   r_dsq;
    logic signed [32:0] n_dx, n_dy;

    assign n_dx = $signed({i_tx[31], i_tx}) - $signed({i_px[31], i_px});
    assign n_dy = $signed({i_ty[31], i_ty}) - $signed({i_py[31], i_py});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
        end else begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mx    <= mag33(n_dx);
        r_my    <= mag33(n_dy);
        r_tag_a <= i_tag;
        r_sx    <= {32'd0, r_mx} * {32'd0, r_mx};
        r_sy    <= {32'd0, r_my} * {32'd0, r_my};
        r_tag_b <= r_tag_a;
        r_dsq   <= {1'b0, r_sx} + {1'b0, r_sy};
        r_tag_c <= r_tag_b;
    end

    assign o_vld = r_vld_c;
    assign o_dsq = r_dsq;
    assign o_tag = r_tag_c;

endmodule

### design/pplt_heading.sv
// ----------------------------------------------------------------------------
// pplt_heading
// yaw cosine and sine in q1.30 from a quaternion, iterative sqrt and divide
// ----------------------------------------------------------------------------
module pplt_heading import pplt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_qw,
    input  logic signed [15:0] i_qx,
    input  logic signed [15:0] i_qy,
    input  logic signed [15:0] i_qz,
    output logic               o_done,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);

    typedef enum logic [9:0] {
        H_IDLE = 10'b0000000001,
        H_PROD = 10'b0000000010,
        H_AB   = 10'b0000000100,
        H_SQ0  = 10'b0000001000,
        H_SQ1  = 10'b0000010000,
        H_SQ2  = 10'b0000100000,
        H_SQRT = 10'b0001000000,
        H_DIVA = 10'b0010000000,
        H_DIVB = 10'b0100000000,
        H_DONE = 10'b1000000000
    } t_hst;

    t_hst               r_st;
    logic signed [15:0] r_qw, r_qx, r_qy, r_qz;
    logic signed [31:0] r_yy, r_zz, r_wz, r_xy;
    logic               r_aneg, r_bneg;
    logic [31:0]        r_ma, r_mb;
    logic [63:0]        r_p, r_v, r_res, r_bit;
    logic [31:0]        r_r;
    logic [31:0]        r_rem;
    logic [61:0]        r_num;
    logic [5:0]         r_cnt;
    logic signed [31:0] r_cos, r_sin;

    logic signed [33:0] n_a, n_b;
    logic [31:0]        n_mop;
    logic [63:0]        n_prod, n_t;
    logic [32:0]        n_rsh;
    logic               n_qbit;
    logic [32:0]        n_qmag;

    assign n_a = 34'sd134217728 - (34'(r_yy) + 34'(r_zz));
    assign n_b = 34'(r_wz) + 34'(r_xy);
    assign n_mop  = r_st[3] ? r_ma : r_mb;
    assign n_prod = {32'd0, n_mop} * {32'd0, n_mop};
    assign n_t    = r_res + r_bit;
    assign n_rsh  = {r_rem, r_num[61]};
    assign n_qbit = (n_rsh >= {1'b0, r_r});
    assign n_qmag = {1'b0, r_num[30:0], n_qbit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= H_IDLE;
        end else begin
            case (r_st)
                H_IDLE: if (i_start) r_st <= H_PROD;
                H_PROD: r_st <= H_AB;
                H_AB:   r_st <= H_SQ0;
                H_SQ0:  r_st <= H_SQ1;
                H_SQ1:  r_st <= H_SQ2;
                H_SQ2:  r_st <= H_SQRT;
                H_SQRT: begin
                    if (r_bit == 64'd1) begin
                        r_st <= (n_t > r_v ? r_res[32:1] : r_res[32:1] + 32'd0) == 32'd0
                                && r_v < n_t && r_res[63:1] == 63'd0 ? H_DONE : H_DIVA;
                    end
                end
                H_DIVA: if (r_cnt == 6'd61) r_st <= H_DIVB;
                H_DIVB: if (r_cnt == 6'd61) r_st <= H_DONE;
                H_DONE: if (i_start) r_st <= H_PROD;
                default: r_st <= H_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            H_IDLE, H_DONE: begin
                if (i_start) begin
                    r_qw <= i_qw;
                    r_qx <= i_qx;
                    r_qy <= i_qy;
                    r_qz <= i_qz;
                end
            end
            H_PROD: begin
                r_yy <= r_qy * r_qy;
                r_zz <= r_qz * r_qz;
                r_wz <= r_qw * r_qz;
                r_xy <= r_qx * r_qy;
            end
            H_AB: begin
                r_aneg <= n_a[33];
                r_bneg <= n_b[33];
                r_ma   <= n_a[33] ? 32'(-n_a) : n_a[31:0];
                r_mb   <= n_b[33] ? 32'(-n_b) : n_b[31:0];
            end
            H_SQ0: r_p <= n_prod;
            H_SQ1: begin
                r_v <= r_p;
                r_p <= n_prod;
            end
            H_SQ2: begin
                r_v   <= r_v + r_p;
                r_res <= 64'd0;
                r_bit <= 64'd1 << 62;
            end
            H_SQRT: begin
                if (r_v >= n_t) begin
                    r_v   <= r_v - n_t;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit == 64'd1) begin
                    r_r   <= (r_v >= n_t) ? 32'((r_res >> 1) + r_bit) : 32'(r_res >> 1);
                    r_rem <= 32'd0;
                    r_cnt <= 6'd0;
                    r_cos <= 32'sd1073741824;
                    r_sin <= 32'sd0;
                    r_num <= {r_ma, 30'd0} + {31'd0,
                             (r_v >= n_t) ? 31'(((r_res >> 1) + r_bit) >> 1)
                                          : 31'((r_res >> 1) >> 1)};
                end
            end
            H_DIVA, H_DIVB: begin
                if (r_cnt == 6'd61) begin
                    r_cnt <= 6'd0;
                    r_rem <= 32'd0;
                    if (r_st == H_DIVA) begin
                        r_cos <= r_aneg ? 32'(-n_qmag) : n_qmag[31:0];
                        r_num <= {r_mb, 30'd0} + {31'd0, r_r[31:1]};
                    end else begin
                        r_sin <= r_bneg ? 32'(-n_qmag) : n_qmag[31:0];
                    end
                end else begin
                    r_rem <= n_qbit ? 32'(n_rsh - {1'b0, r_r}) : n_rsh[31:0];
                    r_num <= {r_num[60:0], n_qbit};
                    r_cnt <= r_cnt + 6'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_done = (r_st == H_DONE);
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

### design/pplt_rotate.sv
// ----------------------------------------------------------------------------
// pplt_rotate
// rotates an offset by a cosine and sine pair with one shared multiplier
// ----------------------------------------------------------------------------
module pplt_rotate import pplt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_dx,
    input  logic signed [32:0] i_dy,
    input  logic signed [31:0] i_cos,
    input  logic signed [31:0] i_sin,
    output logic               o_done,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y
);

    logic               r_busy, r_done;
    logic [2:0]         r_step;
    logic [63:0]        r_prod;
    logic               r_pneg;
    logic signed [65:0] r_acc_x, r_acc_y;

    logic signed [32:0] n_d;
    logic signed [31:0] n_c;
    logic               n_sub;
    logic [31:0]        n_md, n_mc;
    logic signed [65:0] n_term;

    always_comb begin
        case (r_step)
            3'd0:    begin n_d = i_dx; n_c = i_cos; n_sub = 1'b0; end
            3'd1:    begin n_d = i_dy; n_c = i_sin; n_sub = 1'b0; end
            3'd2:    begin n_d = i_dy; n_c = i_cos; n_sub = 1'b0; end
            default: begin n_d = i_dx; n_c = i_sin; n_sub = 1'b1; end
        endcase
    end

    assign n_md   = mag33(n_d);
    assign n_mc   = mag33(33'(n_c));
    assign n_term = r_pneg ? -$signed({2'b00, r_prod}) : $signed({2'b00, r_prod});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 3'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= 3'd0;
        end else if (r_busy) begin
            r_step <= r_step + 3'd1;
            if (r_step == 3'd4) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc_x <= 66'sd0;
            r_acc_y <= 66'sd0;
        end else if (r_busy) begin
            r_prod <= {32'd0, n_md} * {32'd0, n_mc};
            r_pneg <= n_d[32] ^ n_c[31] ^ n_sub;
            if (r_step == 3'd1 || r_step == 3'd2) begin
                r_acc_x <= r_acc_x + n_term;
            end
            if (r_step == 3'd3 || r_step == 3'd4) begin
                r_acc_y <= r_acc_y + n_term;
            end
        end
    end

    function automatic logic signed [31:0] round_sat(input logic signed [65:0] v);
        logic signed [65:0] t;
        logic signed [65:0] q;
        t = v + 66'sd536870912;
        q = t >>> 30;
        if (!q[65] && q[64:31] != 34'd0) return 32'sh7fffffff;
        if (q[65] && q[64:31] != {34{1'b1}}) return 32'sh80000000;
        return q[31:0];
    endfunction

    assign o_done = r_done;
    assign o_x    = round_sat(r_acc_x);
    assign o_y    = round_sat(r_acc_y);

endmodule
